### rtl/lzwbc_pkg.sv
package lzwbc_pkg;

   localparam int LEN_W        = 9;
   localparam int GROUP_BYTES  = 24;
   localparam int GROUP_TOKENS = 8;
   localparam int HDR_LAST     = 15;
   localparam int HDR_LEN_LAST = 7;
   localparam int HDR_LEN_LO   = 4;
   localparam int LONG_MATCH   = 18;
   localparam int MIN_MATCH    = 3;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic CSR_HEADER_MODE  = 1'b0;
   localparam logic CSR_TOTAL_LENGTH = 1'b1;

   localparam logic [7:0] MAGIC_0 = 8'h59;
   localparam logic [7:0] MAGIC_1 = 8'h61;
   localparam logic [7:0] MAGIC_2 = 8'h7A;
   localparam logic [7:0] MAGIC_3 = 8'h30;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

   typedef struct packed {
      logic       is_push;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } emit_type;

   typedef struct packed {
      logic valid;
      logic stream_end;
   } close_type;

   typedef struct packed {
      logic        en;
      logic [31:0] addr;
      logic [7:0]  data;
   } ring_wr_type;

   typedef struct packed {
      logic        start;
      logic        read;
      logic [31:0] pos;
   } srch_cmd_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] len;
      logic [31:0]      src;
      logic [7:0]       rd_data;
   } srch_res_type;

   function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic mode,
                                           input logic [31:0] len);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         4'd0: b = mode ? MAGIC_0 : 8'h00;
         4'd1: b = mode ? MAGIC_1 : 8'h00;
         4'd2: b = mode ? MAGIC_2 : 8'h00;
         4'd3: b = mode ? MAGIC_3 : 8'h00;
         4'd4: b = len[31:24];
         4'd5: b = len[23:16];
         4'd6: b = len[15:8];
         4'd7: b = len[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### rtl/lzwbc_front.sv
module lzwbc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lzwbc_pkg::req_type req_payload,
   output logic               q_valid,
   output lzwbc_pkg::item_type q_item,
   input  logic               q_pop
);
   import lzwbc_pkg::*;

   item_type   ent_ff [2];
   item_type   ent_in [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = ent_ff[rptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      ent_in  = ent_ff;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         ent_in[wptr_ff].is_push = (req_payload.cmd == CMD_PUSH);
         ent_in[wptr_ff].data    = req_payload.data_byte;
         wptr_in                 = ~wptr_ff;
      end
      if (pop) begin
         rptr_in = ~rptr_ff;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

### rtl/lzwbc_search.sv
module lzwbc_search #(
   parameter int WINDOW_SIZE = 4096,
   parameter int MAX_MATCH   = 273,
   parameter int RING_DEPTH  = 8192
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lzwbc_pkg::ring_wr_type  wr,
   input  lzwbc_pkg::srch_cmd_type cmd,
   input  logic [31:0]             total_length,
   output lzwbc_pkg::srch_res_type res
);
   import lzwbc_pkg::*;

   localparam int RW = $clog2(RING_DEPTH);

   typedef enum logic [1:0] {SR_IDLE, SR_ISSUE, SR_CMP, SR_READ} sr_state_type;

   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] rda_ff, rdb_ff;

   sr_state_type     st_ff, st_in;
   logic [31:0]      p_ff, p_in;
   logic [31:0]      m_ff, m_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] ml_ff, ml_in;
   logic [LEN_W-1:0] best_ff, best_in;
   logic [31:0]      bestm_ff, bestm_in;
   logic             done_ff, done_in;
   logic [7:0]       rd_ff, rd_in;

   logic [RW-1:0]    addr_a, addr_b;
   logic [31:0]      rem;
   logic [LEN_W-1:0] ml_new;
   logic [LEN_W-1:0] cand;
   logic [LEN_W-1:0] nbest;
   logic             eq;

   always_comb begin
      addr_a = (st_ff == SR_IDLE) ? cmd.pos[RW-1:0]
                                  : RW'(m_ff + {{(32-LEN_W){1'b0}}, len_ff});
      addr_b = RW'(p_ff + {{(32-LEN_W){1'b0}}, len_ff});
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ring_mem[wr.addr[RW-1:0]] <= wr.data;
      end
      rda_ff <= ring_mem[addr_a];
      rdb_ff <= ring_mem[addr_b];
   end

   always_comb begin
      st_in    = st_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      len_in   = len_ff;
      ml_in    = ml_ff;
      best_in  = best_ff;
      bestm_in = bestm_ff;
      done_in  = 1'b0;
      rd_in    = rd_ff;
      rem      = total_length - cmd.pos;
      ml_new   = (rem > 32'(MAX_MATCH)) ? LEN_W'(MAX_MATCH) : rem[LEN_W-1:0];
      eq       = (rda_ff == rdb_ff);
      cand     = eq ? len_ff + 1'b1 : len_ff;
      nbest    = (cand > best_ff) ? cand : best_ff;
      case (st_ff)
         SR_IDLE: begin
            if (cmd.read) begin
               st_in = SR_READ;
            end else if (cmd.start) begin
               best_in = '0;
               len_in  = '0;
               p_in    = cmd.pos;
               ml_in   = ml_new;
               m_in    = (cmd.pos > 32'(WINDOW_SIZE)) ? cmd.pos - 32'(WINDOW_SIZE) : 32'd0;
               if (cmd.pos >= total_length || ml_new < LEN_W'(MIN_MATCH) ||
                   cmd.pos == 32'd0) begin
                  done_in = 1'b1;
               end else begin
                  st_in = SR_ISSUE;
               end
            end
         end
         SR_ISSUE: begin
            st_in = SR_CMP;
         end
         SR_CMP: begin
            if (eq && (len_ff + 1'b1) < ml_ff) begin
               len_in = len_ff + 1'b1;
               st_in  = SR_ISSUE;
            end else begin
               if (cand > best_ff) begin
                  best_in  = cand;
                  bestm_in = m_ff;
               end
               if (nbest == ml_ff || (m_ff + 32'd1) == p_ff) begin
                  done_in = 1'b1;
                  st_in   = SR_IDLE;
               end else begin
                  m_in   = m_ff + 32'd1;
                  len_in = '0;
                  st_in  = SR_ISSUE;
               end
            end
         end
         SR_READ: begin
            rd_in   = rda_ff;
            done_in = 1'b1;
            st_in   = SR_IDLE;
         end
         default: st_in = SR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      m_ff     <= m_in;
      len_ff   <= len_in;
      ml_ff    <= ml_in;
      best_ff  <= best_in;
      bestm_ff <= bestm_in;
      rd_ff    <= rd_in;
      if (reset) begin
         st_ff   <= SR_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   assign res.done    = done_ff;
   assign res.len     = best_ff;
   assign res.src     = bestm_ff;
   assign res.rd_data = rd_ff;

endmodule

### rtl/lzwbc_engine.sv
module lzwbc_engine #(
   parameter int MAX_MATCH = 273
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    header_mode,
   input  logic [31:0]             total_length,
   input  logic                    q_valid,
   input  lzwbc_pkg::item_type     q_item,
   output logic                    q_pop,
   output lzwbc_pkg::ring_wr_type  wr,
   output lzwbc_pkg::srch_cmd_type cmd,
   input  lzwbc_pkg::srch_res_type res,
   input  logic                    out_ready,
   output lzwbc_pkg::emit_type     emit,
   output lzwbc_pkg::close_type    close
);
   import lzwbc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HDR, ST_STORE, ST_CHECK, ST_S1, ST_S2, ST_LIT, ST_LITW,
      ST_MATCH, ST_TOK, ST_FLUSH, ST_END, ST_CLOSE
   } st_type;

   st_type           st_ff, st_in;
   st_type           ret_ff, ret_in;
   logic             hdr_done_ff, hdr_done_in;
   logic             done_ff, done_in;
   logic [31:0]      rp_ff, rp_in;
   logic [31:0]      br_ff, br_in;
   logic [7:0]       ctrl_ff, ctrl_in;
   logic [3:0]       tok_ff, tok_in;
   logic [4:0]       fill_ff, fill_in;
   logic [7:0]       grp_ff [GROUP_BYTES];
   logic [7:0]       grp_in [GROUP_BYTES];
   logic [3:0]       hidx_ff, hidx_in;
   logic [4:0]       fidx_ff, fidx_in;
   logic [LEN_W-1:0] hl_ff, hl_in;
   logic [31:0]      hp_ff, hp_in;
   logic             mfol_ff, mfol_in;
   logic [7:0]       tb_ff [3];
   logic [7:0]       tb_in [3];
   logic [1:0]       tn_ff, tn_in;
   logic             tlit_ff, tlit_in;
   item_type         it_ff, it_in;
   logic             cend_ff, cend_in;

   logic             long_hdr;
   logic [3:0]       hdr_end;
   logic [32:0]      need;
   logic [11:0]      offs;
   logic [LEN_W-1:0] lm2;
   logic [LEN_W-1:0] lm18;
   logic [4:0]       gi;

   always_comb begin
      st_in       = st_ff;
      ret_in      = ret_ff;
      hdr_done_in = hdr_done_ff;
      done_in     = done_ff;
      rp_in       = rp_ff;
      br_in       = br_ff;
      ctrl_in     = ctrl_ff;
      tok_in      = tok_ff;
      fill_in     = fill_ff;
      grp_in      = grp_ff;
      hidx_in     = hidx_ff;
      fidx_in     = fidx_ff;
      hl_in       = hl_ff;
      hp_in       = hp_ff;
      mfol_in     = mfol_ff;
      tb_in       = tb_ff;
      tn_in       = tn_ff;
      tlit_in     = tlit_ff;
      it_in       = it_ff;
      cend_in     = cend_ff;
      q_pop       = 1'b0;
      wr.en       = 1'b0;
      wr.addr     = br_ff;
      wr.data     = it_ff.data;
      cmd.start   = 1'b0;
      cmd.read    = 1'b0;
      cmd.pos     = rp_ff;
      emit.valid  = 1'b0;
      emit.data   = 8'h00;
      close.valid = 1'b0;
      close.stream_end = cend_ff;

      long_hdr = header_mode || (total_length == 32'd0);
      hdr_end  = long_hdr ? 4'(HDR_LAST) : 4'(HDR_LEN_LAST);
      need     = {1'b0, rp_ff} + 33'(MAX_MATCH) + 33'd1;
      if (need > {1'b0, total_length}) begin
         need = {1'b0, total_length};
      end
      offs = 12'(rp_ff - hp_ff - 32'd1);
      lm2  = hl_ff - LEN_W'(2);
      lm18 = hl_ff - LEN_W'(LONG_MATCH);
      gi   = fidx_ff - 5'd1;

      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               it_in = q_item;
               if (done_ff) begin
                  st_in = ST_IDLE;
               end else if (!hdr_done_ff) begin
                  hdr_done_in = 1'b1;
                  hidx_in     = long_hdr ? 4'd0 : 4'(HDR_LEN_LO);
                  st_in       = ST_HDR;
               end else begin
                  st_in = ST_STORE;
               end
            end
         end
         ST_HDR: begin
            emit.data = hdr_byte(hidx_ff, header_mode, total_length);
            if (out_ready) begin
               emit.valid = 1'b1;
               hidx_in    = hidx_ff + 4'd1;
               if (hidx_ff == hdr_end) begin
                  if (total_length == 32'd0) begin
                     done_in = 1'b1;
                     cend_in = 1'b1;
                     st_in   = ST_CLOSE;
                  end else begin
                     st_in = ST_STORE;
                  end
               end
            end
         end
         ST_STORE: begin
            if (it_ff.is_push && br_ff < total_length) begin
               wr.en = 1'b1;
               br_in = br_ff + 32'd1;
            end
            st_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rp_ff < total_length && {1'b0, br_ff} >= need) begin
               cmd.start = 1'b1;
               st_in     = ST_S1;
            end else begin
               st_in = ST_END;
            end
         end
         ST_S1: begin
            if (res.done) begin
               hl_in = res.len;
               hp_in = res.src;
               if (res.len < LEN_W'(MIN_MATCH)) begin
                  mfol_in = 1'b0;
                  st_in   = ST_LIT;
               end else begin
                  cmd.start = 1'b1;
                  cmd.pos   = rp_ff + 32'd1;
                  st_in     = ST_S2;
               end
            end
         end
         ST_S2: begin
            if (res.done) begin
               mfol_in = 1'b1;
               if ((hl_ff + 1'b1) < res.len) begin
                  hl_in = res.len;
                  hp_in = res.src;
                  st_in = ST_LIT;
               end else begin
                  st_in = ST_MATCH;
               end
            end
         end
         ST_LIT: begin
            cmd.read = 1'b1;
            st_in    = ST_LITW;
         end
         ST_LITW: begin
            if (res.done) begin
               tb_in[0] = res.rd_data;
               tn_in    = 2'd1;
               tlit_in  = 1'b1;
               rp_in    = rp_ff + 32'd1;
               st_in    = ST_TOK;
            end
         end
         ST_MATCH: begin
            mfol_in = 1'b0;
            tlit_in = 1'b0;
            tb_in[1] = offs[7:0];
            if (hl_ff < LEN_W'(LONG_MATCH)) begin
               tb_in[0] = {lm2[3:0], offs[11:8]};
               tn_in    = 2'd2;
            end else begin
               tb_in[0] = {4'h0, offs[11:8]};
               tb_in[2] = lm18[7:0];
               tn_in    = 2'd3;
            end
            rp_in = rp_ff + {{(32-LEN_W){1'b0}}, hl_ff};
            st_in = ST_TOK;
         end
         ST_TOK: begin
            for (int k = 0; k < 3; k++) begin
               if (2'(k) < tn_ff && (fill_ff + 5'(k)) < 5'(GROUP_BYTES)) begin
                  grp_in[fill_ff + 5'(k)] = tb_ff[k];
               end
            end
            fill_in = fill_ff + {3'b000, tn_ff};
            if (tlit_ff) begin
               ctrl_in = ctrl_ff | (8'h80 >> tok_ff[2:0]);
            end
            tok_in = tok_ff + 4'd1;
            ret_in = mfol_ff ? ST_MATCH : ST_END;
            if (tok_ff + 4'd1 == 4'(GROUP_TOKENS)) begin
               fidx_in = '0;
               st_in   = ST_FLUSH;
            end else begin
               st_in = mfol_ff ? ST_MATCH : ST_END;
            end
         end
         ST_FLUSH: begin
            emit.data = (fidx_ff == 5'd0) ? ctrl_ff : grp_ff[gi];
            if (out_ready) begin
               emit.valid = 1'b1;
               fidx_in    = fidx_ff + 5'd1;
               if (fidx_ff == fill_ff) begin
                  fill_in = '0;
                  ctrl_in = '0;
                  tok_in  = '0;
                  st_in   = ret_ff;
               end
            end
         end
         ST_END: begin
            if (rp_ff >= total_length) begin
               done_in = 1'b1;
               cend_in = 1'b1;
               if (tok_ff != 4'd0) begin
                  fidx_in = '0;
                  ret_in  = ST_CLOSE;
                  st_in   = ST_FLUSH;
               end else begin
                  st_in = ST_CLOSE;
               end
            end else begin
               cend_in = 1'b0;
               st_in   = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (out_ready) begin
               close.valid = 1'b1;
               st_in       = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      grp_ff  <= grp_in;
      hidx_ff <= hidx_in;
      fidx_ff <= fidx_in;
      hl_ff   <= hl_in;
      hp_ff   <= hp_in;
      tb_ff   <= tb_in;
      tn_ff   <= tn_in;
      tlit_ff <= tlit_in;
      it_ff   <= it_in;
      ret_ff  <= ret_in;
      mfol_ff <= mfol_in;
      cend_ff <= cend_in;
      if (reset) begin
         st_ff       <= ST_IDLE;
         hdr_done_ff <= 1'b0;
         done_ff     <= 1'b0;
         rp_ff       <= '0;
         br_ff       <= '0;
         ctrl_ff     <= '0;
         tok_ff      <= '0;
         fill_ff     <= '0;
      end else begin
         st_ff       <= st_in;
         hdr_done_ff <= hdr_done_in;
         done_ff     <= done_in;
         rp_ff       <= rp_in;
         br_ff       <= br_in;
         ctrl_ff     <= ctrl_in;
         tok_ff      <= tok_in;
         fill_ff     <= fill_in;
      end
   end

endmodule

### rtl/lzwbc_out.sv
module lzwbc_out (
   input  logic                 clock,
   input  logic                 reset,
   input  lzwbc_pkg::emit_type  emit,
   input  lzwbc_pkg::close_type close,
   output logic                 out_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lzwbc_pkg::rsp_type   rsp_payload
);
   import lzwbc_pkg::*;

   logic       pv_ff, pv_in;
   logic [7:0] pb_ff, pb_in;
   logic       rv_ff, rv_in;
   rsp_type    rb_ff, rb_in;

   assign out_ready   = !rv_ff || rsp_ready;
   assign rsp_valid   = rv_ff;
   assign rsp_payload = rb_ff;

   always_comb begin
      pv_in = pv_ff;
      pb_in = pb_ff;
      rb_in = rb_ff;
      rv_in = rv_ff && !rsp_ready;
      if (emit.valid) begin
         if (pv_ff) begin
            rb_in = '{out_byte: pb_ff, run_last: 1'b0, stream_end: 1'b0};
            rv_in = 1'b1;
         end
         pv_in = 1'b1;
         pb_in = emit.data;
      end else if (close.valid && pv_ff) begin
         rb_in = '{out_byte: pb_ff, run_last: 1'b1, stream_end: close.stream_end};
         rv_in = 1'b1;
         pv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pb_ff <= pb_in;
      rb_ff <= rb_in;
      if (reset) begin
         pv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
         rv_ff <= rv_in;
      end
   end

endmodule

### rtl/lz_window_byte_compressor.sv
// Processing: the engine handles one beat at a time; a coded position runs up to two window
// searches of WINDOW_SIZE candidates, comparing bytes over the shared ring read ports;
// the first beat adds 4 or 16 header bytes.
// Reset: synchronous, active high; clears control state, header_mode to 1, total_length
// to 0. The history ring is not cleared and needs no clearing pass.
module lz_window_byte_compressor #(
   parameter int WINDOW_SIZE = 4096,
   parameter int MAX_MATCH   = 273,
   parameter int RING_DEPTH  = 8192
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lzwbc_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lzwbc_pkg::rsp_type rsp_payload,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);
   import lzwbc_pkg::*;

   logic         header_mode_ff;
   logic [31:0]  total_length_ff;
   logic         q_valid;
   item_type     q_item;
   logic         q_pop;
   ring_wr_type  wr;
   srch_cmd_type cmd;
   srch_res_type res;
   logic         out_ready;
   emit_type     emit;
   close_type    close;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_mode_ff  <= 1'b1;
         total_length_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HEADER_MODE:  header_mode_ff  <= csr_wdata[0];
            CSR_TOTAL_LENGTH: total_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   lzwbc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   lzwbc_search #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .MAX_MATCH   (MAX_MATCH),
      .RING_DEPTH  (RING_DEPTH)
   ) u_search (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .cmd          (cmd),
      .total_length (total_length_ff),
      .res          (res)
   );

   lzwbc_engine #(
      .MAX_MATCH (MAX_MATCH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .header_mode  (header_mode_ff),
      .total_length (total_length_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .wr           (wr),
      .cmd          (cmd),
      .res          (res),
      .out_ready    (out_ready),
      .emit         (emit),
      .close        (close)
   );

   lzwbc_out u_out (
      .clock       (clock),
      .reset       (reset),
      .emit        (emit),
      .close       (close),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.stream_end |-> rsp_payload.run_last)
      else $error("stream end without run end");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.stream_end |=> !rsp_valid)
      else $error("beat after stream end");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_single_op: assert property (@(posedge clock) disable iff (reset)
      !(emit.valid && close.valid))
      else $error("emit and close together");
`endif

endmodule
